/* hdl/periodic_event_timer_table_top_macros.svh */
// Assertion macros for the periodic event timer table.
// Needs signals named clock and reset in the scope of each use.
`ifndef PERIODIC_EVENT_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_EVENT_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define PETT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PETT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pett_pkg.sv */
// Shared types, codes and defaults of the periodic event timer table.
// No dependencies.
package pett_pkg;

   localparam int SLOTS_DEFAULT      = 16;
   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int FUNC_W   = 2;
   localparam int PERIOD_W = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int TICK_W   = 32;

   localparam logic [TICK_W-1:0] TICK_LENGTH_RESET = 32'd1;

   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 2'd2;

   typedef struct packed {
      logic set_en;
      logic clear_en;
      logic dec_en;
   } alloc_ctl_type;

endpackage

/* hdl/pett_slot_alloc.sv */
// Slot occupancy flags, live count and lowest-free-slot search.
// Depends on pett_pkg and the assertion macro header.
`include "periodic_event_timer_table_top_macros.svh"

module pett_slot_alloc #(
   parameter int SLOTS = pett_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pett_pkg::alloc_ctl_type     ctl,
   input  logic [pett_pkg::SLOT_W-1:0] query_slot,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] free_slot,
   output logic                        has_free,
   output logic                        query_live,
   output logic [$clog2(SLOTS+1)-1:0]  live_count
);
   import pett_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS+1);

   logic [SLOTS-1:0] slot_in_use_ff, slot_in_use_in;
   logic [CW-1:0]    live_count_ff, live_count_in;
   logic [SW-1:0]    query_idx;

   always_comb begin
      free_slot = '0;
      has_free  = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_in_use_ff[i]) begin
            free_slot = SW'(i);
            has_free  = 1'b1;
         end
      end
   end

   assign query_idx  = SW'(query_slot);
   assign query_live = (32'(query_slot) < 32'(SLOTS)) && slot_in_use_ff[query_idx];

   always_comb begin
      slot_in_use_in = slot_in_use_ff;
      live_count_in  = live_count_ff;
      if (ctl.set_en) begin
         slot_in_use_in[free_slot] = 1'b1;
         live_count_in             = live_count_ff + CW'(1);
      end
      if (ctl.clear_en) begin
         slot_in_use_in[query_idx] = 1'b0;
      end
      if (ctl.dec_en) begin
         live_count_in = live_count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_in_use_ff <= '0;
         live_count_ff  <= '0;
      end else begin
         slot_in_use_ff <= slot_in_use_in;
         live_count_ff  <= live_count_in;
      end
   end

   assign live_count = live_count_ff;

   `PETT_ASSERT_NOW(a_count_tracks_flags, 1'b1,
      ($countones(slot_in_use_ff) == 32'(live_count_ff)) ||
      ($countones(slot_in_use_ff) + 1 == 32'(live_count_ff)),
      "live count out of step with occupancy flags")
   `PETT_ASSERT_NOW(a_set_needs_free, ctl.set_en, has_free, "allocation with no free slot")
   `PETT_ASSERT_NOW(a_clear_needs_live, ctl.clear_en, query_live, "release of a free slot")
   `PETT_ASSERT_NOW(a_dec_needs_live, ctl.dec_en, live_count_ff != '0, "live count underflow")

endmodule

/* hdl/periodic_event_timer_table_top.sv */
// Top level of the periodic event timer table: sequencer, event memories, result register.
// Depends on pett_pkg, pett_slot_alloc and the assertion macro header.
//
// Periodic event timer table: one transaction at a time. Create and a destroy of a free slot
// answer straight from the idle state. A destroy of a live slot sweeps the firing order memory
// to close the gap. A tick walks the live events, or goes straight to its final answer when no
// event is live, and can wait on a stalled result channel: each live event costs one read of
// the firing order memory followed by one read of its period and countdown and a write-back of
// the countdown. No clearing pass runs after reset; the block takes a transaction in the first
// cycle after reset.
`include "periodic_event_timer_table_top_macros.svh"

module periodic_event_timer_table_top #(
   parameter int SLOTS      = pett_pkg::SLOTS_DEFAULT,
   parameter int TIME_WIDTH = pett_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [pett_pkg::TICK_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pett_pkg::FUNC_W-1:0]   req_func,
   input  logic [pett_pkg::PERIOD_W-1:0] req_period,
   input  logic [pett_pkg::SLOT_W-1:0]   req_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pett_pkg::STATUS_W-1:0] rsp_status,
   output logic [pett_pkg::SLOT_W-1:0]   rsp_event_slot,
   output logic                          rsp_fired,
   output logic                          rsp_last
);
   import pett_pkg::*;

   localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS+1);
   localparam int TW   = TIME_WIDTH;
   localparam int CMPW = (TW > TICK_W) ? TW : TICK_W;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_T_RD   = 7'b0000010,
      ST_T_EV   = 7'b0000100,
      ST_T_UPD  = 7'b0001000,
      ST_T_FIN  = 7'b0010000,
      ST_D_RD   = 7'b0100000,
      ST_D_WALK = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [SW-1:0]     target_ff, target_in;
   logic              found_ff, found_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [SW-1:0]     pend_slot_ff, pend_slot_in;
   logic [TICK_W-1:0] tick_length_ff;

   logic [TW-1:0] period_mem_ff [SLOTS];
   logic [TW-1:0] count_mem_ff  [SLOTS];
   logic [SW-1:0] order_mem_ff  [SLOTS];
   logic [TW-1:0] period_q_ff, count_q_ff;
   logic [SW-1:0] order_q_ff;

   logic          order_we, period_we, count_we;
   logic [SW-1:0] order_wa, order_wd, order_ra, count_wa, ev_ra;
   logic [TW-1:0] count_wd, period_trunc, count_next;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_event_slot_ff;
   logic                rsp_fired_ff, rsp_last_ff;
   logic                rsp_load, ld_fired, ld_last;
   logic [STATUS_W-1:0] ld_status;
   logic [SW-1:0]       ld_slot;

   alloc_ctl_type alloc_ctl;
   logic [SW-1:0] free_slot;
   logic          has_free, query_live;
   logic [CW-1:0] live_count;

   logic            out_free, req_accept, fire;
   logic [CMPW-1:0] count_ext, tick_ext;

   pett_slot_alloc #(.SLOTS(SLOTS)) u_alloc (
      .clock      (clock),
      .reset      (reset),
      .ctl        (alloc_ctl),
      .query_slot (req_slot),
      .free_slot  (free_slot),
      .has_free   (has_free),
      .query_live (query_live),
      .live_count (live_count)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != ST_IDLE) || !out_free;
   assign req_accept   = req_valid && !req_stall;
   assign period_trunc = TW'(req_period);
   assign count_ext    = CMPW'(count_q_ff);
   assign tick_ext     = CMPW'(tick_length_ff);
   assign fire         = count_ext <= tick_ext;
   assign count_next   = fire ? period_q_ff : TW'(count_ext - tick_ext);
   assign order_ra     = idx_ff[SW-1:0];
   assign ev_ra        = (state_ff == ST_T_EV) ? order_q_ff : slot_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      target_in     = target_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      alloc_ctl     = '0;
      rsp_load      = 1'b0;
      ld_status     = STATUS_OK;
      ld_slot       = '0;
      ld_fired      = 1'b0;
      ld_last       = 1'b1;
      order_we      = 1'b0;
      order_wa      = SW'(idx_ff - CW'(2));
      order_wd      = order_q_ff;
      period_we     = 1'b0;
      count_we      = 1'b0;
      count_wa      = slot_ff;
      count_wd      = count_next;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_TICK: begin
                     idx_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = (live_count == '0) ? ST_T_FIN : ST_T_RD;
                  end
                  FUNC_CREATE: begin
                     rsp_load = 1'b1;
                     if (has_free) begin
                        alloc_ctl.set_en = 1'b1;
                        period_we        = 1'b1;
                        count_we         = 1'b1;
                        count_wa         = free_slot;
                        count_wd         = period_trunc;
                        order_we         = 1'b1;
                        order_wa         = SW'(live_count);
                        order_wd         = free_slot;
                        ld_slot          = free_slot;
                     end else begin
                        ld_status = STATUS_FULL;
                     end
                  end
                  FUNC_DESTROY: begin
                     if (query_live) begin
                        alloc_ctl.clear_en = 1'b1;
                        target_in          = SW'(req_slot);
                        idx_in             = '0;
                        found_in           = 1'b0;
                        state_in           = ST_D_RD;
                     end else begin
                        rsp_load  = 1'b1;
                        ld_status = STATUS_NOT_IN_USE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_T_RD: begin
            state_in = ST_T_EV;
         end
         ST_T_EV: begin
            slot_in  = order_q_ff;
            idx_in   = idx_ff + CW'(1);
            state_in = ST_T_UPD;
         end
         ST_T_UPD: begin
            if (!(fire && pend_valid_ff && !out_free)) begin
               count_we = 1'b1;
               if (fire) begin
                  if (pend_valid_ff) begin
                     rsp_load = 1'b1;
                     ld_slot  = pend_slot_ff;
                     ld_fired = 1'b1;
                     ld_last  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = slot_ff;
               end
               state_in = (idx_ff == live_count) ? ST_T_FIN : ST_T_EV;
            end
         end
         ST_T_FIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (pend_valid_ff) begin
                  ld_slot  = pend_slot_ff;
                  ld_fired = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_D_RD: begin
            idx_in   = CW'(1);
            state_in = ST_D_WALK;
         end
         ST_D_WALK: begin
            if (found_ff) begin
               order_we = 1'b1;
            end else if (order_q_ff == target_ff) begin
               found_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
            if (idx_ff == live_count) begin
               alloc_ctl.dec_en = 1'b1;
               rsp_load         = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (period_we) begin
         period_mem_ff[count_wa] <= period_trunc;
      end
      if (count_we) begin
         count_mem_ff[count_wa] <= count_wd;
      end
      if (order_we) begin
         order_mem_ff[order_wa] <= order_wd;
      end
      period_q_ff <= period_mem_ff[ev_ra];
      count_q_ff  <= count_mem_ff[ev_ra];
      order_q_ff  <= order_mem_ff[order_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_valid_ff  <= 1'b0;
         found_ff       <= 1'b0;
         idx_ff         <= '0;
         tick_length_ff <= TICK_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         idx_ff        <= idx_in;
         if (csr_wr_en) begin
            tick_length_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      target_ff    <= target_in;
      pend_slot_ff <= pend_slot_in;
      if (rsp_load) begin
         rsp_status_ff     <= ld_status;
         rsp_event_slot_ff <= SLOT_W'(ld_slot);
         rsp_fired_ff      <= ld_fired;
         rsp_last_ff       <= ld_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_event_slot = rsp_event_slot_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_last       = rsp_last_ff;

   `PETT_ASSERT_NOW(a_no_overwrite, rsp_load && rsp_valid_ff, !rsp_stall,
      "result register overwritten while stalled")
   `PETT_ASSERT_NOW(a_pend_in_tick, pend_valid_ff,
      (state_ff == ST_T_EV) || (state_ff == ST_T_UPD) || (state_ff == ST_T_FIN),
      "held firing outside a tick walk")
   `PETT_ASSERT_NOW(a_walk_in_range, state_ff == ST_T_UPD,
      (idx_ff != '0) && (idx_ff <= live_count), "tick walk index beyond live events")
   `PETT_ASSERT_NEXT(a_create_answers, req_accept && (req_func == FUNC_CREATE),
      rsp_valid_ff && rsp_last_ff && !rsp_fired_ff, "create transaction left unanswered")

endmodule
